>>> rtl/bpg_pkg.sv
// bpg_pkg: shared types, constants and register indexes for the button gesture classifier
// no dependencies
`default_nettype none

package bpg_pkg;

   localparam int TIME_WIDTH = 32;
   localparam int NOW_WIDTH  = 32;
   localparam int HOLD_WIDTH = 16;
   localparam int MODE_WIDTH = 2;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [MODE_WIDTH-1:0] MODE_SHORT = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_LONG  = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_HOLD  = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GESTURE_MODE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_TIME    = 2'd1;

   localparam logic [HOLD_WIDTH-1:0] HOLD_TIME_RESET = 16'd666;

   typedef struct packed {
      logic [MODE_WIDTH-1:0] gesture_mode;
      logic [HOLD_WIDTH-1:0] hold_time_ms;
   } cfg_type;

   typedef struct packed {
      logic                 pressed_sample;
      logic                 sample_valid;
      logic [NOW_WIDTH-1:0] now_ms;
   } item_type;

   typedef struct packed {
      logic gesture_active;
      logic button_value;
      logic on_activate;
      logic on_deactivate;
      logic previous_value;
   } result_type;

endpackage

`default_nettype wire

>>> rtl/bpg_csr.sv
// bpg_csr: configuration registers, gesture mode and hold threshold
// depends on bpg_pkg
`default_nettype none

module bpg_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [bpg_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [bpg_pkg::HOLD_WIDTH-1:0]      csr_data,
   output bpg_pkg::cfg_type                         cfg
);

   bpg_pkg::cfg_type cfg_ff;

   // no transfer while reset holds the registers
   assign csr_ready = !reset;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gesture_mode <= bpg_pkg::MODE_SHORT;
         cfg_ff.hold_time_ms <= bpg_pkg::HOLD_TIME_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            bpg_pkg::CSR_GESTURE_MODE: begin
               cfg_ff.gesture_mode <= csr_data[bpg_pkg::MODE_WIDTH-1:0];
            end
            bpg_pkg::CSR_HOLD_TIME: begin
               cfg_ff.hold_time_ms <= csr_data;
            end
            default: begin
               // writes beyond the register list are dropped
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> rtl/bpg_in_reg.sv
// bpg_in_reg: input register for one button poll
// depends on bpg_pkg
`default_nettype none

module bpg_in_reg (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_pressed_sample,
   input  wire logic                          req_sample_valid,
   input  wire logic [bpg_pkg::NOW_WIDTH-1:0] req_now_ms,
   input  wire logic                          take,
   output logic                               item_valid,
   output bpg_pkg::item_type                  item
);

   logic              valid_ff;
   logic              valid_in;
   bpg_pkg::item_type item_ff;

   // accept when empty or when the held poll moves on this cycle, never in reset
   assign req_ready  = !reset && (!valid_ff || take);
   assign valid_in   = req_valid || (valid_ff && !take);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= req_ready ? req_valid : valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.pressed_sample <= req_pressed_sample;
         item_ff.sample_valid   <= req_sample_valid;
         item_ff.now_ms         <= req_now_ms;
      end
   end

endmodule

`default_nettype wire

>>> rtl/bpg_classify.sv
// bpg_classify: gesture state, classification logic and result register
// depends on bpg_pkg
`default_nettype none

module bpg_classify (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire bpg_pkg::cfg_type   cfg,
   input  wire logic               item_valid,
   input  wire bpg_pkg::item_type  item,
   output logic                    take,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output bpg_pkg::result_type     result
);

   logic                            pressed_ff;
   logic [bpg_pkg::TIME_WIDTH-1:0]  start_ff;
   logic                            fired_ff;
   logic                            active_ff;
   logic                            value_ff;
   logic                            rsp_valid_ff;
   bpg_pkg::result_type             result_ff;

   logic                            pressed_in;
   logic [bpg_pkg::TIME_WIDTH-1:0]  start_in;
   logic                            fired_in;
   logic                            active_in;
   logic                            value_in;
   logic                            rsp_valid_in;

   logic                            changed;
   logic                            press_edge;
   logic [bpg_pkg::TIME_WIDTH-1:0]  now_t;
   logic [bpg_pkg::TIME_WIDTH-1:0]  elapsed;
   logic                            below_hold;

   assign take = item_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      pressed_in = item.sample_valid ? item.pressed_sample : pressed_ff;
      changed    = pressed_in != pressed_ff;
      press_edge = changed && pressed_in;
      now_t      = item.now_ms[bpg_pkg::TIME_WIDTH-1:0];
      start_in   = press_edge ? now_t : start_ff;
      fired_in   = press_edge ? 1'b0 : fired_ff;
      // wrapping difference, threshold zero-extended
      elapsed    = now_t - start_in;
      below_hold = elapsed < bpg_pkg::TIME_WIDTH'(cfg.hold_time_ms);
      active_in  = 1'b0;
      value_in   = value_ff;
      case (cfg.gesture_mode)
         bpg_pkg::MODE_SHORT: begin
            active_in = changed && !pressed_in && below_hold;
            value_in  = pressed_in;
         end
         bpg_pkg::MODE_LONG: begin
            if (pressed_in && !fired_in && !below_hold) begin
               active_in = 1'b1;
               fired_in  = 1'b1;
               value_in  = 1'b1;
            end
            if (changed && !pressed_in) begin
               value_in = 1'b0;
            end
         end
         default: begin
            // hold, and the unused code behaves as hold
            active_in = pressed_in;
            value_in  = pressed_in;
         end
      endcase
      rsp_valid_in = take || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff   <= 1'b0;
         start_ff     <= '0;
         fired_ff     <= 1'b0;
         active_ff    <= 1'b0;
         value_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            pressed_ff <= pressed_in;
            start_ff   <= start_in;
            fired_ff   <= fired_in;
            active_ff  <= active_in;
            value_ff   <= value_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff.gesture_active <= active_in;
         result_ff.button_value   <= value_in;
         result_ff.on_activate    <= !active_ff && active_in;
         result_ff.on_deactivate  <= active_ff && !active_in;
         result_ff.previous_value <= value_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

endmodule

`default_nettype wire

>>> rtl/button_press_gesture_classifier_top.sv
// button_press_gesture_classifier_top: short press, long press and hold detector
// depends on bpg_pkg, bpg_csr, bpg_in_reg, bpg_classify
//
//   channel   direction  handshake              payload
//   req       in         req_valid/req_ready    pressed_sample, sample_valid, now_ms
//   rsp       out        rsp_valid/rsp_ready    gesture_active, button_value,
//                                               on_activate, on_deactivate, previous_value
//   csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// one poll per cycle sustained while rsp_ready stays high; rsp_valid rises once the req transfer
// has passed the input register, then classification into the result register
// the result register holds while rsp_ready is low and the input register takes
// one more poll behind it; req_ready drops only when both are full
// synchronous reset clears the gesture state, mode to short press, threshold to 666 ms
// req_ready and csr_ready are low during reset; csr_ready is high otherwise
`default_nettype none

module button_press_gesture_classifier_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_pressed_sample,
   input  wire logic                                req_sample_valid,
   input  wire logic [bpg_pkg::NOW_WIDTH-1:0]       req_now_ms,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_gesture_active,
   output logic                                     rsp_button_value,
   output logic                                     rsp_on_activate,
   output logic                                     rsp_on_deactivate,
   output logic                                     rsp_previous_value,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [bpg_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [bpg_pkg::HOLD_WIDTH-1:0]      csr_data
);

   bpg_pkg::cfg_type    cfg;
   bpg_pkg::item_type   item;
   bpg_pkg::result_type result;
   logic                item_valid;
   logic                take;

   bpg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bpg_in_reg u_in_reg (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pressed_sample (req_pressed_sample),
      .req_sample_valid   (req_sample_valid),
      .req_now_ms         (req_now_ms),
      .take               (take),
      .item_valid         (item_valid),
      .item               (item)
   );

   bpg_classify u_classify (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .result     (result)
   );

   assign rsp_gesture_active = result.gesture_active;
   assign rsp_button_value   = result.button_value;
   assign rsp_on_activate    = result.on_activate;
   assign rsp_on_deactivate  = result.on_deactivate;
   assign rsp_previous_value = result.previous_value;

endmodule

`default_nettype wire

>>> bench/bpg_gesture_monitor.sv
// bpg_gesture_monitor: watches the poll, result and register channels of the classifier,
// predicts every result from its own copy of the gesture state and compares field by field
// depends on bpg_pkg
module bpg_gesture_monitor (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_ready,
   input  wire logic                                req_pressed_sample,
   input  wire logic                                req_sample_valid,
   input  wire logic [bpg_pkg::NOW_WIDTH-1:0]       req_now_ms,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   input  wire logic                                rsp_gesture_active,
   input  wire logic                                rsp_button_value,
   input  wire logic                                rsp_on_activate,
   input  wire logic                                rsp_on_deactivate,
   input  wire logic                                rsp_previous_value,
   input  wire logic                                csr_valid,
   input  wire logic                                csr_ready,
   input  wire logic [bpg_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [bpg_pkg::HOLD_WIDTH-1:0]      csr_data,
   output int                                       mismatch_count,
   output int                                       gestures_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   bpg_pkg::cfg_type               gesture_cfg;
   logic                           pressed_q;
   logic [bpg_pkg::TIME_WIDTH-1:0] press_start_q;
   logic                           long_fired_q;
   logic                           active_q;
   logic                           value_q;

   bpg_pkg::result_type expected_gestures[$];

   task automatic report_mismatch(input string msg);
      $display("gesture monitor: %s at %0t", msg, $time);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic got, input logic want);
      if (got !== want)
         report_mismatch($sformatf("%s got %b want %b", name, got, want));
   endtask

   // classify one poll and advance the gesture state
   function automatic bpg_pkg::result_type classify_poll(input bpg_pkg::item_type poll);
      bpg_pkg::result_type            outcome;
      logic [bpg_pkg::TIME_WIDTH-1:0] now_t;
      logic [bpg_pkg::TIME_WIDTH-1:0] elapsed;
      logic [bpg_pkg::TIME_WIDTH-1:0] threshold;
      logic                           was_pressed;
      logic                           was_active;
      logic                           edge_seen;
      logic                           hit;
      now_t = bpg_pkg::TIME_WIDTH'(poll.now_ms);
      threshold = bpg_pkg::TIME_WIDTH'(gesture_cfg.hold_time_ms);
      was_pressed = pressed_q;
      was_active = active_q;
      outcome.previous_value = value_q;
      hit = 1'b0;
      if (poll.sample_valid)
         pressed_q = poll.pressed_sample;
      edge_seen = (was_pressed != pressed_q);
      // a fresh press restarts the timer in every mode
      if (edge_seen && pressed_q) begin
         press_start_q = now_t;
         long_fired_q = 1'b0;
      end
      elapsed = now_t - press_start_q;
      case (gesture_cfg.gesture_mode)
         bpg_pkg::MODE_SHORT: begin
            hit = edge_seen && !pressed_q && (elapsed < threshold);
            value_q = pressed_q;
         end
         bpg_pkg::MODE_LONG: begin
            if (pressed_q && !long_fired_q && elapsed >= threshold) begin
               hit = 1'b1;
               long_fired_q = 1'b1;
               value_q = 1'b1;
            end
            if (edge_seen && !pressed_q)
               value_q = 1'b0;
         end
         default: begin
            // hold, and the unused code behaves the same
            hit = pressed_q;
            value_q = pressed_q;
         end
      endcase
      active_q = hit;
      outcome.gesture_active = hit;
      outcome.button_value = value_q;
      outcome.on_activate = !was_active && hit;
      outcome.on_deactivate = was_active && !hit;
      return outcome;
   endfunction

   always @(posedge clock) begin : watch
      bpg_pkg::result_type got;
      bpg_pkg::result_type want;
      bpg_pkg::item_type   poll;
      if (reset) begin
         gesture_cfg.gesture_mode = bpg_pkg::MODE_SHORT;
         gesture_cfg.hold_time_ms = bpg_pkg::HOLD_TIME_RESET;
         pressed_q = 1'b0;
         press_start_q = '0;
         long_fired_q = 1'b0;
         active_q = 1'b0;
         value_q = 1'b0;
         expected_gestures.delete();
         gestures_pending <= 0;
      end else begin
         // compare before predicting so a stray result never meets a fresh prediction
         if (rsp_valid && rsp_ready) begin
            got = {rsp_gesture_active, rsp_button_value, rsp_on_activate,
                   rsp_on_deactivate, rsp_previous_value};
            if (expected_gestures.size() == 0) begin
               report_mismatch("result transfer with no poll waiting");
            end else begin
               want = expected_gestures.pop_front();
               check_field("gesture_active", got.gesture_active, want.gesture_active);
               check_field("button_value", got.button_value, want.button_value);
               check_field("on_activate", got.on_activate, want.on_activate);
               check_field("on_deactivate", got.on_deactivate, want.on_deactivate);
               check_field("previous_value", got.previous_value, want.previous_value);
            end
         end
         if (req_valid && req_ready) begin
            poll.pressed_sample = req_pressed_sample;
            poll.sample_valid = req_sample_valid;
            poll.now_ms = req_now_ms;
            expected_gestures = {expected_gestures, classify_poll(poll)};
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bpg_pkg::CSR_GESTURE_MODE:
                  gesture_cfg.gesture_mode = bpg_pkg::MODE_WIDTH'(csr_data);
               bpg_pkg::CSR_HOLD_TIME:
                  gesture_cfg.hold_time_ms = csr_data;
               default: ;
            endcase
         end
         gestures_pending <= expected_gestures.size();
      end
   end

endmodule

>>> bench/tb_top.sv
// tb_top: clock, reset and stimulus for button_press_gesture_classifier_top, and the verdict
// depends on bpg_pkg, button_press_gesture_classifier_top and bpg_gesture_monitor
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic                                req_pressed_sample = 1'b0;
   logic                                req_sample_valid = 1'b0;
   logic [bpg_pkg::NOW_WIDTH-1:0]       req_now_ms = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic                                rsp_gesture_active;
   logic                                rsp_button_value;
   logic                                rsp_on_activate;
   logic                                rsp_on_deactivate;
   logic                                rsp_previous_value;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [bpg_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [bpg_pkg::HOLD_WIDTH-1:0]      csr_data = '0;
   int                                  mismatch_count;
   int                                  gestures_pending;

   bit long_stall_wanted = 1'b0;
   int burst_left = 0;

   button_press_gesture_classifier_top i_dut (.*);

   bpg_gesture_monitor i_monitor (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("button_press_gesture_classifier_top: mismatch");
      $finish;
   end

   // result side: runs of steady, patchy or stalled ready, plus one long hold-off
   initial begin : receiver
      int  run_len;
      int  style;
      bit  stall_done;
      stall_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (long_stall_wanted && !stall_done) begin
            stall_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
         end
         style = $urandom_range(0, 3);
         run_len = (style == 3) ? $urandom_range(1, 8) : $urandom_range(1, 40);
         repeat (run_len) begin
            case (style)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= 1'($urandom);
               default: rsp_ready <= 1'b0;
            endcase
            @(posedge clock);
         end
      end
   end

   task automatic send_poll(input logic pressed, input logic valid,
                            input logic [bpg_pkg::NOW_WIDTH-1:0] now);
      req_valid <= 1'b1;
      req_pressed_sample <= pressed;
      req_sample_valid <= valid;
      req_now_ms <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // bursts of random length with random gaps between them
   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (gestures_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input logic [bpg_pkg::HOLD_WIDTH-1:0] mode_word,
                             input logic [bpg_pkg::HOLD_WIDTH-1:0] hold);
      csr_valid <= 1'b1;
      csr_index <= bpg_pkg::CSR_GESTURE_MODE;
      csr_data <= mode_word;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= bpg_pkg::CSR_HOLD_TIME;
      csr_data <= hold;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int                             items_sent;
      int                             phase;
      int                             phase_items;
      int                             hold_i;
      int                             span;
      int                             kind;
      logic [1:0]                     mode_sel;
      logic [bpg_pkg::HOLD_WIDTH-1:0] hold;
      logic [bpg_pkg::HOLD_WIDTH-1:0] upper;
      logic [bpg_pkg::NOW_WIDTH-1:0]  now;
      logic [bpg_pkg::NOW_WIDTH-1:0]  press_at;
      logic                           level;
      logic                           toggle;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: short press at 666 ms, just under and exactly at the threshold
      send_poll(1'b0, 1'b1, 32'd0);
      send_poll(1'b1, 1'b1, 32'd100);
      send_poll(1'b0, 1'b0, 32'd150);
      send_poll(1'b0, 1'b1, 32'd765);
      send_poll(1'b1, 1'b1, 32'd1000);
      send_poll(1'b0, 1'b1, 32'd1666);
      send_poll(1'b1, 1'b0, 32'd1700);
      drain();

      // zero threshold in long mode fires on the press poll
      set_config(bpg_pkg::HOLD_WIDTH'(bpg_pkg::MODE_LONG), 16'd0);
      send_poll(1'b1, 1'b1, 32'd5);
      send_poll(1'b1, 1'b1, 32'd6);
      send_poll(1'b0, 1'b1, 32'd7);
      drain();

      // widest threshold across the timestamp wrap
      set_config(bpg_pkg::HOLD_WIDTH'(bpg_pkg::MODE_LONG), 16'hFFFF);
      send_poll(1'b1, 1'b1, 32'hFFFF_FF00);
      send_poll(1'b1, 1'b1, 32'h0000_FEFE);
      send_poll(1'b1, 1'b1, 32'h0000_FEFF);
      send_poll(1'b0, 1'b1, 32'h0001_0000);
      drain();

      set_config(bpg_pkg::HOLD_WIDTH'(bpg_pkg::MODE_SHORT), 16'hFFFF);
      send_poll(1'b1, 1'b1, 32'hFFFF_FFF0);
      send_poll(1'b0, 1'b1, 32'h0000_FFEE);
      send_poll(1'b1, 1'b1, 32'd10);
      drain();

      // mode switch mid-press: long mode picks up the press made in short mode
      set_config(bpg_pkg::HOLD_WIDTH'(bpg_pkg::MODE_LONG), 16'd20);
      send_poll(1'b1, 1'b1, 32'd40);
      drain();

      set_config(bpg_pkg::HOLD_WIDTH'(bpg_pkg::MODE_HOLD), 16'd20);
      send_poll(1'b1, 1'b1, 32'd41);
      send_poll(1'b0, 1'b0, 32'd42);
      send_poll(1'b0, 1'b1, 32'd43);
      drain();

      // unused mode code, upper data bits set
      set_config(16'hFFFF, 16'd20);
      send_poll(1'b1, 1'b1, 32'd44);
      send_poll(1'b0, 1'b1, 32'd45);
      drain();

      // zero threshold never gives a short press
      set_config(bpg_pkg::HOLD_WIDTH'(bpg_pkg::MODE_SHORT), 16'd0);
      send_poll(1'b1, 1'b1, 32'd50);
      send_poll(1'b0, 1'b1, 32'd50);
      drain();

      items_sent = 0;
      phase = 0;
      while (items_sent < 1950) begin
         mode_sel = 2'($urandom_range(0, 3));
         case ($urandom_range(0, 5))
            0: hold = '0;
            1: hold = '1;
            2: hold = bpg_pkg::HOLD_WIDTH'($urandom_range(1, 40));
            3, 4: hold = bpg_pkg::HOLD_WIDTH'($urandom_range(1, 2000));
            default: hold = bpg_pkg::HOLD_WIDTH'($urandom);
         endcase
         upper = ($urandom_range(0, 3) == 0) ? bpg_pkg::HOLD_WIDTH'($urandom) : '0;
         set_config({upper[bpg_pkg::HOLD_WIDTH-1:bpg_pkg::MODE_WIDTH], mode_sel}, hold);
         if (phase == 2)
            long_stall_wanted = 1'b1;
         hold_i = int'(hold);
         span = hold_i + hold_i / 2 + 2;
         if ($urandom_range(0, 3) == 0)
            now = 32'hFFFF_FFFF - 32'($urandom_range(0, 3 * hold_i + 10));
         else
            now = $urandom;
         level = 1'b0;
         press_at = now;
         phase_items = $urandom_range(100, 200);
         repeat (phase_items) begin
            pace();
            kind = $urandom_range(0, 19);
            if (kind == 0) begin
               // noise: any level, any validity, any time
               send_poll(1'($urandom), 1'($urandom), $urandom);
            end else if (kind <= 3) begin
               now = now + 32'($urandom_range(0, span));
               send_poll(1'($urandom), 1'b0, now);
            end else begin
               toggle = ($urandom_range(0, 2) == 0);
               // land right around the threshold now and then
               if ($urandom_range(0, 3) == 0)
                  now = press_at + 32'(hold) + 32'($urandom_range(0, 2)) - 32'd1;
               else
                  now = now + 32'($urandom_range(0, span));
               if (toggle)
                  level = !level;
               if (toggle && level)
                  press_at = now;
               send_poll(level, 1'b1, now);
            end
         end
         items_sent += phase_items;
         phase++;
         drain();
      end

      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && gestures_pending == 0)
         $display("button_press_gesture_classifier_top: match");
      else
         $display("button_press_gesture_classifier_top: mismatch");
      $finish;
   end

endmodule

>>> filelist.f
rtl/bpg_pkg.sv
rtl/bpg_csr.sv
rtl/bpg_in_reg.sv
rtl/bpg_classify.sv
rtl/button_press_gesture_classifier_top.sv
bench/bpg_gesture_monitor.sv
bench/tb_top.sv
